// File: sv/utf8_stream_decoder_macros.svh
// Assertion macros used by the decoder RTL.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define UTF8SD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8sd assertion failed");

// Next-cycle implication, checked only out of reset.
`define UTF8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8sd assertion failed");

`endif

// File: sv/utf8sd_pkg.sv
`timescale 1ns / 1ps

package utf8sd_pkg;

  // Field widths.
  localparam int CP_W    = 21;
  localparam int USED_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int PAY_W   = 12;
  localparam int MAX_RES = 3;
  localparam int CNT_W   = 2;
  localparam int LEN_W   = 3;

  // Replacement codepoint after reset: question mark.
  localparam logic [CP_W-1:0] REPL_RESET = 21'h00003f;

  // Sequence lengths; LEN_NONE means no sequence is pending.
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

  // Lead and second-byte bounds for overlong, surrogate and range checks.
  localparam logic [BYTE_W-1:0] LEAD_MIN2  = 8'hc2;
  localparam logic [BYTE_W-1:0] LEAD_E0    = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hed;
  localparam logic [BYTE_W-1:0] LEAD_F0    = 8'hf0;
  localparam logic [BYTE_W-1:0] LEAD_F4    = 8'hf4;
  localparam logic [BYTE_W-1:0] SEC_MIN_E0 = 8'ha0;
  localparam logic [BYTE_W-1:0] SEC_MAX_ED = 8'h9f;
  localparam logic [BYTE_W-1:0] SEC_MIN_F0 = 8'h90;
  localparam logic [BYTE_W-1:0] SEC_MAX_F4 = 8'h8f;

  // One result item.
  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic [USED_W-1:0] used;
    logic              bad;
  } res_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    logic                      eot;
    res_t [MAX_RES-1:0]        ent;
  } grp_t;

endpackage

// File: sv/utf8sd_core.sv
`timescale 1ns / 1ps

module utf8sd_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  logic [utf8sd_pkg::BYTE_W-1:0]     text_byte,
  input  logic                              end_of_text,
  input  logic [utf8sd_pkg::CP_W-1:0]       repl_code,
  output utf8sd_pkg::grp_t                  grp,
  output logic                              seq_busy
);

  logic [utf8sd_pkg::LEN_W-1:0]  exp_r, exp_nxt;
  logic [utf8sd_pkg::LEN_W-1:0]  rcv_r, rcv_nxt;
  logic [utf8sd_pkg::BYTE_W-1:0] lead_r, lead_nxt;
  logic [utf8sd_pkg::BYTE_W-1:0] sec_r, sec_nxt;
  logic [utf8sd_pkg::PAY_W-1:0]  pay_r, pay_nxt;

  logic [utf8sd_pkg::LEN_W-1:0]  rcv_inc;
  logic [utf8sd_pkg::BYTE_W-1:0] sec_cur;
  logic                          range_bad;
  logic [utf8sd_pkg::CP_W-1:0]   lead_part;
  logic [utf8sd_pkg::CP_W-1:0]   cp_data;
  logic                          do_clear;

  assign rcv_inc = rcv_r + 3'd1;
  assign sec_cur = (rcv_inc == 3'd2) ? text_byte : sec_r;
  assign seq_busy = (exp_r != utf8sd_pkg::LEN_NONE);

  // Overlong, surrogate and above-range checks on lead and second byte.
  always_comb begin
    case (exp_r)
      utf8sd_pkg::LEN_2: begin
        range_bad = (lead_r < utf8sd_pkg::LEAD_MIN2);
      end
      utf8sd_pkg::LEN_3: begin
        range_bad = ((lead_r == utf8sd_pkg::LEAD_E0) && (sec_cur < utf8sd_pkg::SEC_MIN_E0)) ||
                    ((lead_r == utf8sd_pkg::LEAD_ED) && (sec_cur > utf8sd_pkg::SEC_MAX_ED));
      end
      default: begin
        range_bad = ((lead_r == utf8sd_pkg::LEAD_F0) && (sec_cur < utf8sd_pkg::SEC_MIN_F0)) ||
                    ((lead_r == utf8sd_pkg::LEAD_F4) && (sec_cur > utf8sd_pkg::SEC_MAX_F4));
      end
    endcase
  end

  // Codepoint assembly from lead bits, gathered payload and the final tail.
  always_comb begin
    case (exp_r)
      utf8sd_pkg::LEN_2: lead_part = {10'd0, lead_r[4:0], 6'd0};
      utf8sd_pkg::LEN_3: lead_part = {5'd0, lead_r[3:0], 12'd0};
      default:           lead_part = {lead_r[2:0], 18'd0};
    endcase
    cp_data = lead_part | {3'd0, pay_r, text_byte[5:0]};
  end

  // Next state and result group for the byte at the input.
  always_comb begin
    exp_nxt  = exp_r;
    rcv_nxt  = rcv_r;
    lead_nxt = lead_r;
    sec_nxt  = sec_r;
    pay_nxt  = pay_r;
    do_clear = 1'b0;
    grp.cnt  = 2'd0;
    grp.eot  = end_of_text;
    for (int i = 0; i < utf8sd_pkg::MAX_RES; i++) begin
      grp.ent[i] = {repl_code, 3'd1, 1'b1};
    end

    if (exp_r == utf8sd_pkg::LEN_NONE) begin
      if (text_byte[7] == 1'b0) begin
        grp.cnt    = 2'd1;
        grp.ent[0] = {13'd0, text_byte, 3'd1, 1'b0};
      end else if (text_byte[7:5] == 3'b110) begin
        exp_nxt  = utf8sd_pkg::LEN_2;
        rcv_nxt  = 3'd1;
        lead_nxt = text_byte;
        sec_nxt  = '0;
        pay_nxt  = '0;
      end else if (text_byte[7:4] == 4'he) begin
        exp_nxt  = utf8sd_pkg::LEN_3;
        rcv_nxt  = 3'd1;
        lead_nxt = text_byte;
        sec_nxt  = '0;
        pay_nxt  = '0;
      end else if (text_byte >= utf8sd_pkg::LEAD_F0 && text_byte <= utf8sd_pkg::LEAD_F4) begin
        exp_nxt  = utf8sd_pkg::LEN_4;
        rcv_nxt  = 3'd1;
        lead_nxt = text_byte;
        sec_nxt  = '0;
        pay_nxt  = '0;
      end else begin
        // Stray tail byte or a lead that can never start a valid sequence.
        grp.cnt = 2'd1;
      end
    end else if (text_byte[7:6] != 2'b10) begin
      // Bad tail: swallow the pending bytes and the offending byte.
      grp.cnt         = 2'd1;
      grp.ent[0].used = rcv_inc;
      do_clear        = 1'b1;
    end else if (rcv_inc < exp_r) begin
      rcv_nxt = rcv_inc;
      sec_nxt = sec_cur;
      pay_nxt = {pay_r[5:0], text_byte[5:0]};
    end else if (range_bad) begin
      // One replacement for the lead part, then one for each remaining tail.
      grp.cnt         = (exp_r == utf8sd_pkg::LEN_4) ? 2'd3 : 2'd2;
      grp.ent[0].used = (exp_r == utf8sd_pkg::LEN_2) ? 3'd1 : 3'd2;
      do_clear        = 1'b1;
    end else begin
      grp.cnt    = 2'd1;
      grp.ent[0] = {cp_data, exp_r, 1'b0};
      do_clear   = 1'b1;
    end

    // A sequence cut short by the end of the text gives one replacement.
    if (end_of_text && !do_clear && (exp_nxt != utf8sd_pkg::LEN_NONE)) begin
      grp.cnt         = 2'd1;
      grp.ent[0].used = rcv_nxt;
      do_clear        = 1'b1;
    end

    if (do_clear) begin
      exp_nxt  = utf8sd_pkg::LEN_NONE;
      rcv_nxt  = '0;
      lead_nxt = '0;
      sec_nxt  = '0;
      pay_nxt  = '0;
    end
  end

  // Sequence state advances once per byte taken from the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= utf8sd_pkg::LEN_NONE;
      rcv_r  <= '0;
      lead_r <= '0;
      sec_r  <= '0;
      pay_r  <= '0;
    end else if (step_en) begin
      exp_r  <= exp_nxt;
      rcv_r  <= rcv_nxt;
      lead_r <= lead_nxt;
      sec_r  <= sec_nxt;
      pay_r  <= pay_nxt;
    end
  end

endmodule

// File: sv/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload
// in_      slave      tdata[7:0] text_byte, tlast end_of_text
// out_     master     tdata[20:0] code_point, tdata[23:21] bytes_used,
//                     tuser[0] malformed, tuser[1] text_done, tlast last_of_run
// cfg_     slave      data[20:0] replacement_code
//
// One byte per cycle is accepted while each byte yields at most one result.
// A byte waits in the input register, then its results (0 to 3) load the
// result register and leave at one per cycle while out_tready is high; the
// single-port result register sets the rate when a byte yields two or three
// results. Reset (rst_n low, synchronous) idles the decoder and restores '?'
// as the replacement code. Back-pressure on out_ holds the input register.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] bytes_used
  output logic [1:0]  out_tuser,  // [0] malformed, [1] text_done
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data    // [20:0] replacement_code
);

  logic [utf8sd_pkg::CP_W-1:0]   repl_r;
  logic                          s1_valid_r;
  logic [utf8sd_pkg::BYTE_W-1:0] s1_byte_r;
  logic                          s1_eot_r;
  utf8sd_pkg::grp_t              grp_r;
  utf8sd_pkg::grp_t              core_grp;
  logic [utf8sd_pkg::CNT_W-1:0]  grp_idx_r;
  logic                          grp_free;
  logic                          s1_adv;
  logic                          seq_busy;
  logic                          cur_last;
  utf8sd_pkg::res_t              cur_ent;

  // Configuration register, writable at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= utf8sd_pkg::REPL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      repl_r <= cfg_data;
    end
  end

  // The result register can take a new group when it is empty or drains this cycle.
  assign grp_free  = (grp_idx_r == grp_r.cnt) ||
                     (((grp_idx_r + 2'd1) == grp_r.cnt) && out_tready);
  assign s1_adv    = s1_valid_r && grp_free;
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_eot_r  <= in_tlast;
    end
  end

  // Decode logic and sequence state.
  utf8sd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_adv),
    .text_byte   (s1_byte_r),
    .end_of_text (s1_eot_r),
    .repl_code   (repl_r),
    .grp         (core_grp),
    .seq_busy    (seq_busy)
  );

  // Result register: a group of results and the index of the next one out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r.cnt <= '0;
      grp_idx_r <= '0;
    end else if (s1_adv) begin
      grp_r     <= core_grp;
      grp_idx_r <= '0;
    end else if (out_tvalid && out_tready) begin
      grp_idx_r <= grp_idx_r + 2'd1;
    end
  end

  // Select the current result.
  always_comb begin
    case (grp_idx_r)
      2'd1:    cur_ent = grp_r.ent[1];
      2'd2:    cur_ent = grp_r.ent[2];
      default: cur_ent = grp_r.ent[0];
    endcase
  end

  assign cur_last   = ((grp_idx_r + 2'd1) == grp_r.cnt);
  assign out_tvalid = (grp_idx_r != grp_r.cnt);
  assign out_tdata  = {cur_ent.used, cur_ent.cp};
  assign out_tuser  = {cur_last && grp_r.eot, cur_ent.bad};
  assign out_tlast  = cur_last;

  // The read index never runs past the group size.
  `UTF8SD_ASSERT_SAME(a_idx_bound, clk, rst_n, 1'b1, grp_idx_r <= grp_r.cnt)
  // After the last result of a group leaves without a reload, output goes idle.
  `UTF8SD_ASSERT_NEXT(a_drain_idle, clk, rst_n,
    out_tvalid && out_tready && out_tlast && !s1_adv, !out_tvalid)
  // The end of a text always closes a run.
  `UTF8SD_ASSERT_SAME(a_done_last, clk, rst_n, out_tvalid && out_tuser[1], out_tlast)
  // No sequence stays pending past an end-of-text byte.
  `UTF8SD_ASSERT_NEXT(a_eot_idle, clk, rst_n, s1_adv && s1_eot_r, !seq_busy)

endmodule
